### rtl/wtcg_pkg.sv
package wtcg_pkg;

    localparam int PIXEL_BYTES = 4;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int MAX_TEX_LOG2_DEFAULT = 10;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [10:0] WIDTH_RESET = 11'd64;
    localparam logic [10:0] WIDTH_MAX = 11'd1024;
    localparam logic [3:0] HLOG_RESET = 4'd6;
    localparam logic [11:0] SCREEN_RESET = 12'd480;

    // s_tdata bit positions
    localparam int IN_SIDE = 0;
    localparam int IN_SXP = 1;
    localparam int IN_SYP = 2;
    localparam int IN_POS_X = 3;
    localparam int IN_POS_Y = 29;
    localparam int IN_DIST = 55;
    localparam int IN_RDX = 81;
    localparam int IN_RDY = 99;
    localparam int IN_LH = 117;
    localparam int IN_START = 130;
    localparam int IN_TDATA_W = 144;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0] {
        REG_TEX_WIDTH = 2'd0,
        REG_TEX_HEIGHT_LOG2 = 2'd1,
        REG_SCREEN_HEIGHT = 2'd2,
        REG_VIEW_PITCH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TEX_EAST = 2'd0,
        TEX_WEST = 2'd1,
        TEX_SOUTH = 2'd2,
        TEX_NORTH = 2'd3
    } texture_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_HIT,
        ST_COL,
        ST_MIR,
        ST_DIV,
        ST_POS
    } back_state_t;

    // effective configuration, already clamped
    typedef struct packed {
        logic [10:0]        width;
        logic [3:0]         hlog;
        logic [11:0]        screen_height;
        logic signed [11:0] view_pitch;
    } cfg_t;

    // queue entry, classified by the front part
    typedef struct packed {
        logic               is_row;
        texture_t           texture;
        logic               mirror;
        logic [25:0]        base;
        logic signed [17:0] dir;
        logic [25:0]        perp;
        logic [12:0]        lh;
        logic [10:0]        start;
    } item_t;

    typedef struct packed {
        logic [21:0] texel_offset;
        logic [9:0]  texel_row;
        logic [9:0]  texel_column;
        logic [1:0]  texture_select;
    } result_t;

endpackage

### rtl/wtcg_front.sv
module wtcg_front #(
    parameter int QUEUE_DEPTH = wtcg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wtcg_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,
    output logic                              head_valid,
    output wtcg_pkg::item_t                   head,
    input  logic                              pop
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    wtcg_pkg::item_t entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    wtcg_pkg::item_t item;
    logic side;
    logic signed [17:0] rdx;
    logic signed [17:0] rdy;
    logic [12:0] lh_raw;
    logic push;

    always_comb
    begin
        side = s_tdata[wtcg_pkg::IN_SIDE];
        rdx = s_tdata[wtcg_pkg::IN_RDX +: 18];
        rdy = s_tdata[wtcg_pkg::IN_RDY +: 18];
        lh_raw = s_tdata[wtcg_pkg::IN_LH +: 13];
        item.is_row = s_tuser;
        if (side == 1'b0)
        begin
            item.texture = s_tdata[wtcg_pkg::IN_SXP] ? wtcg_pkg::TEX_EAST : wtcg_pkg::TEX_WEST;
            item.base = s_tdata[wtcg_pkg::IN_POS_Y +: 26];
            item.dir = rdy;
            item.mirror = !rdx[17] && (rdx != 18'sd0);
        end
        else
        begin
            item.texture = s_tdata[wtcg_pkg::IN_SYP] ? wtcg_pkg::TEX_SOUTH
                                                     : wtcg_pkg::TEX_NORTH;
            item.base = s_tdata[wtcg_pkg::IN_POS_X +: 26];
            item.dir = rdx;
            item.mirror = rdy[17];
        end
        item.perp = s_tdata[wtcg_pkg::IN_DIST +: 26];
        // zero line height behaves as one
        item.lh = (lh_raw == 13'd0) ? 13'd1 : lh_raw;
        item.start = s_tdata[wtcg_pkg::IN_START +: 11];
    end

    assign s_tready = (count_reg != CW'(QUEUE_DEPTH));
    assign push = s_tvalid && s_tready;
    assign head_valid = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(QUEUE_DEPTH)) && !pop |=> !s_tready)
        else $error("full queue freed without a pop");
`endif

endmodule

### rtl/wtcg_div.sv
module wtcg_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic busy_reg;
    logic done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic ge;
    logic last;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        diff = shifted - {1'b0, den_reg};
        ge = (shifted >= {1'b0, den_reg});
        last = (cnt_reg == CNT_W'(NUM_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### rtl/wtcg_back.sv
module wtcg_back #(
    parameter int FRAC_BITS = wtcg_pkg::FRAC_BITS_DEFAULT,
    parameter int MAX_TEX_LOG2 = wtcg_pkg::MAX_TEX_LOG2_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wtcg_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  wtcg_pkg::item_t    head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output wtcg_pkg::result_t  m_result
);

    localparam int F2 = 2 * FRAC_BITS;
    localparam int NUM_W = MAX_TEX_LOG2 + FRAC_BITS + 1;
    localparam int ROW_W = MAX_TEX_LOG2;
    localparam int OFF_W = (ROW_W + 15 > 22) ? ROW_W + 15 : 22;
    localparam int PROD_W = 45;
    localparam logic [2:0] BPP = 3'(wtcg_pkg::PIXEL_BYTES);

    wtcg_pkg::back_state_t state_reg, state_next;

    logic [1:0] cur_texture_reg;
    logic [9:0] cur_column_reg;
    logic [31:0] row_position_reg;
    logic [31:0] row_step_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic [F2-1:0] frac_reg;
    logic [F2+10:0] colprod_reg;
    logic signed [14:0] term_reg;
    logic [25:0] base_reg;
    logic [1:0] tex_hold_reg;
    logic mirror_reg;

    logic out_valid_reg;
    wtcg_pkg::result_t out_reg;

    logic out_free;
    logic row_go;
    logic div_start;
    logic div_done;
    logic [NUM_W-1:0] div_num;
    logic [NUM_W-1:0] div_quot;
    logic [NUM_W+31:0] quot_ext;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [14:0] term_next;
    logic [25+FRAC_BITS:0] base_sh;
    logic [F2-1:0] frac_next;
    logic [F2+10:0] colprod_next;
    logic [10:0] col_raw;
    logic [10:0] col_mir;
    logic [31:0] term_ext;
    logic [31:0] pos_prod;

    logic [ROW_W-1:0] row_mask;
    logic [ROW_W-1:0] row_val;
    logic [ROW_W+9:0] row_ext;
    logic [ROW_W+11:0] lin;
    logic [OFF_W-1:0] off_full;
    wtcg_pkg::result_t row_result;

    assign div_num = {{(NUM_W-1){1'b0}}, 1'b1} << (6'(cfg.hlog) + 6'(FRAC_BITS));

    wtcg_div #(
        .NUM_W(NUM_W),
        .DEN_W(13)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (head.lh),
        .done  (div_done),
        .quot  (div_quot)
    );

    // setup arithmetic
    always_comb
    begin
        prod_next = $signed({1'b0, head.perp}) * head.dir;
        term_next = $signed({4'b0, head.start})
                  - $signed({{3{cfg.view_pitch[11]}}, cfg.view_pitch})
                  - $signed({4'b0, cfg.screen_height[11:1]})
                  + $signed({3'b0, head.lh[12:1]});
        base_sh = {base_reg, {FRAC_BITS{1'b0}}};
        frac_next = base_sh[F2-1:0] + prod_reg[F2-1:0];
        colprod_next = frac_reg * cfg.width;
        col_raw = colprod_reg[F2 +: 11];
        col_mir = mirror_reg ? (cfg.width - col_raw - 11'd1) : col_raw;
        quot_ext = {32'b0, div_quot};
        term_ext = {{17{term_reg[14]}}, term_reg};
        pos_prod = term_ext * row_step_reg;
    end

    // row arithmetic
    always_comb
    begin
        row_mask = ~({ROW_W{1'b1}} << cfg.hlog);
        row_val = row_position_reg[FRAC_BITS +: ROW_W] & row_mask;
        row_ext = {10'b0, row_val};
        lin = cfg.width * row_val + cur_column_reg;
        off_full = lin * BPP;
        row_result.texture_select = cur_texture_reg;
        row_result.texel_column = cur_column_reg;
        row_result.texel_row = row_ext[9:0];
        row_result.texel_offset = off_full[21:0];
    end

    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wtcg_pkg::ST_RUN:
            begin
                if (head_valid && !head.is_row)
                begin
                    state_next = wtcg_pkg::ST_HIT;
                end
            end
            wtcg_pkg::ST_HIT: state_next = wtcg_pkg::ST_COL;
            wtcg_pkg::ST_COL: state_next = wtcg_pkg::ST_MIR;
            wtcg_pkg::ST_MIR: state_next = wtcg_pkg::ST_DIV;
            wtcg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = wtcg_pkg::ST_POS;
                end
            end
            wtcg_pkg::ST_POS: state_next = wtcg_pkg::ST_RUN;
            default: state_next = wtcg_pkg::ST_RUN;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop = 1'b0;
        row_go = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            wtcg_pkg::ST_RUN:
            begin
                if (head_valid)
                begin
                    if (head.is_row)
                    begin
                        row_go = out_free;
                        pop = out_free;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        pop = 1'b1;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtcg_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
            cur_texture_reg <= '0;
            cur_column_reg <= '0;
            row_position_reg <= '0;
            row_step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (row_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == wtcg_pkg::ST_MIR)
            begin
                cur_column_reg <= col_mir[9:0];
                cur_texture_reg <= tex_hold_reg;
            end
            if (div_done)
            begin
                row_step_reg <= quot_ext[31:0];
            end
            if (state_reg == wtcg_pkg::ST_POS)
            begin
                row_position_reg <= pos_prod;
            end
            else if (row_go)
            begin
                row_position_reg <= row_position_reg + row_step_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            prod_reg <= prod_next;
            term_reg <= term_next;
            base_reg <= head.base;
            tex_hold_reg <= head.texture;
            mirror_reg <= head.mirror;
        end
        if (state_reg == wtcg_pkg::ST_HIT)
        begin
            frac_reg <= frac_next;
        end
        if (state_reg == wtcg_pkg::ST_COL)
        begin
            colprod_reg <= colprod_next;
        end
        if (row_go)
        begin
            out_reg <= row_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_result = out_reg;

`ifndef SYNTHESIS
    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != wtcg_pkg::ST_RUN) |-> !pop)
        else $error("item taken during setup");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == wtcg_pkg::ST_DIV))
        else $error("divider finished outside wait state");

    a_row_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        row_go |-> (!out_valid_reg || m_ready))
        else $error("row result would overwrite pending output");

    a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_ready |=> out_valid_reg)
        else $error("pending result dropped");
`endif

endmodule

### rtl/wall_texture_coordinate_generator_unit.sv
// Wall texture coordinate generator for one raycaster screen column.
// Input stream (s_*): s_tuser = 0 is a column setup item, 1 a row item.
// A setup item picks the wall texture, the mirrored texel column, the
// vertical step (texture height / line height) and the start row position;
// it produces no output. Each row item produces one output transfer with
// texture, column, row and byte offset, then advances the row position.
// Output stream (m_*) is one result register.
// A row item reaches m_tvalid in the cycle after it leaves the input
// queue; rows sustain one transfer per cycle while m_tready is high. A setup item
// occupies the back end through its HIT, COL, MIR, DIV and POS states, DIV
// waiting on the bit-serial divider for the step; rows queued behind it wait.
// An input queue of QUEUE_DEPTH entries keeps s_tready high while the back
// end works or m_tready is low; once it fills, s_tready drops.
// A stalled output keeps its data; no result is lost or repeated.
// Reset clears the queue, the output valid flag and the column state
// (texture 0, column 0, step 0) and loads the register reset values.
// Registers over APB at byte addresses 0, 4, 8, 12: tex_width,
// tex_height_log2, screen_height, view_pitch; write them only while idle.
module wall_texture_coordinate_generator_unit #(
    parameter int FRAC_BITS = wtcg_pkg::FRAC_BITS_DEFAULT,
    parameter int MAX_TEX_LOG2 = wtcg_pkg::MAX_TEX_LOG2_DEFAULT,
    parameter int QUEUE_DEPTH = wtcg_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // side, step_x_positive, step_y_positive, pos_x, pos_y, perp_dist,
    // ray x, ray y, slice height, slice start row, zero pad
    input  logic [wtcg_pkg::IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // texture_select, texel_column, texel_row, texel_offset, zero pad
    output logic [wtcg_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [3:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [10:0] tex_width_reg;
    logic [3:0] tex_height_log2_reg;
    logic [11:0] screen_height_reg;
    logic [11:0] view_pitch_reg;

    wtcg_pkg::cfg_reg_t reg_sel;
    wtcg_pkg::cfg_t cfg;
    wtcg_pkg::item_t head;
    wtcg_pkg::result_t result;
    logic head_valid;
    logic pop;
    logic cfg_write;

    assign pready = 1'b1;
    assign reg_sel = wtcg_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg <= wtcg_pkg::WIDTH_RESET;
            tex_height_log2_reg <= wtcg_pkg::HLOG_RESET;
            screen_height_reg <= wtcg_pkg::SCREEN_RESET;
            view_pitch_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                wtcg_pkg::REG_TEX_WIDTH: tex_width_reg <= pwdata[10:0];
                wtcg_pkg::REG_TEX_HEIGHT_LOG2: tex_height_log2_reg <= pwdata[3:0];
                wtcg_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[11:0];
                wtcg_pkg::REG_VIEW_PITCH: view_pitch_reg <= pwdata[11:0];
                default: view_pitch_reg <= view_pitch_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wtcg_pkg::REG_TEX_WIDTH: prdata = {21'b0, tex_width_reg};
            wtcg_pkg::REG_TEX_HEIGHT_LOG2: prdata = {28'b0, tex_height_log2_reg};
            wtcg_pkg::REG_SCREEN_HEIGHT: prdata = {20'b0, screen_height_reg};
            wtcg_pkg::REG_VIEW_PITCH: prdata = {20'b0, view_pitch_reg};
            default: prdata = '0;
        endcase
    end

    // clamp width to 1..1024 and height log2 to the supported maximum
    always_comb
    begin
        if (tex_width_reg == 11'd0)
        begin
            cfg.width = 11'd1;
        end
        else if (tex_width_reg > wtcg_pkg::WIDTH_MAX)
        begin
            cfg.width = wtcg_pkg::WIDTH_MAX;
        end
        else
        begin
            cfg.width = tex_width_reg;
        end
        cfg.hlog = (tex_height_log2_reg > 4'(MAX_TEX_LOG2)) ? 4'(MAX_TEX_LOG2)
                                                            : tex_height_log2_reg;
        cfg.screen_height = screen_height_reg;
        cfg.view_pitch = view_pitch_reg;
    end

    wtcg_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    wtcg_back #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_TEX_LOG2 (MAX_TEX_LOG2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (result)
    );

    assign m_tdata = {4'b0, result};

endmodule
